// File: rtl/bnms_pkg.sv
package bnms_pkg;

  // IoU epsilon, added to the union area in the same units as the box area products
  localparam logic [33:0] IOU_EPS = 34'd430;
  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd32768;

  typedef struct packed {
    logic [7:0]  box_class;
    logic [15:0] confidence;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
    logic        last_box;
  } box_req_t;

  typedef struct packed {
    logic [7:0]  kept_class;
    logic [15:0] kept_confidence;
    logic [15:0] kept_left_x;
    logic [15:0] kept_top_y;
    logic [15:0] kept_right_x;
    logic [15:0] kept_bottom_y;
    logic        final_result;
    logic        nothing_kept;
    logic        set_overflowed;
  } box_res_t;

  // one stored box
  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] conf;
    logic [15:0] lx;
    logic [15:0] ty;
    logic [15:0] rx;
    logic [15:0] by;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_INIT,
    ST_FIND,
    ST_FIND_WAIT,
    ST_DECIDE,
    ST_TEST,
    ST_SUPP_INIT,
    ST_SUPP,
    ST_SUPP_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic rd_en;
    logic supp_mode;
    logic find_clr;
    logic take_winner;
    logic push_survivor;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic best_found;
    logic best_zero;
    logic a_supp;
    logic pipe_idle;
  } status_t;

  // extent of one axis, zero when inverted
  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    span = (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

endpackage

// File: rtl/bnms_ctrl.sv
module bnms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last_box,
  input  bnms_pkg::status_t   status,
  output bnms_pkg::cmd_t      cmd,
  output logic                busy
);

  bnms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bnms_pkg::ST_IDLE: begin
        if (start && last_box) state_next = bnms_pkg::ST_FIND_INIT;
      end
      bnms_pkg::ST_FIND_INIT: state_next = bnms_pkg::ST_FIND;
      bnms_pkg::ST_FIND: begin
        if (status.scan_end) state_next = bnms_pkg::ST_FIND_WAIT;
      end
      bnms_pkg::ST_FIND_WAIT: state_next = bnms_pkg::ST_DECIDE;
      bnms_pkg::ST_DECIDE: begin
        if (!status.best_found || status.best_zero) state_next = bnms_pkg::ST_FLUSH;
        else state_next = bnms_pkg::ST_TEST;
      end
      bnms_pkg::ST_TEST: begin
        if (status.a_supp) state_next = bnms_pkg::ST_FIND_INIT;
        else state_next = bnms_pkg::ST_SUPP_INIT;
      end
      bnms_pkg::ST_SUPP_INIT: state_next = bnms_pkg::ST_SUPP;
      bnms_pkg::ST_SUPP: begin
        if (status.scan_end) state_next = bnms_pkg::ST_SUPP_DRAIN;
      end
      bnms_pkg::ST_SUPP_DRAIN: begin
        if (status.pipe_idle) state_next = bnms_pkg::ST_FIND_INIT;
      end
      bnms_pkg::ST_FLUSH: state_next = bnms_pkg::ST_IDLE;
      default: state_next = bnms_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      bnms_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      bnms_pkg::ST_FIND_INIT: begin
        cmd.scan_clr = 1'b1;
        cmd.find_clr = 1'b1;
      end
      bnms_pkg::ST_FIND: cmd.rd_en = 1'b1;
      bnms_pkg::ST_FIND_WAIT: cmd = '0;
      bnms_pkg::ST_DECIDE: begin
        cmd.take_winner = status.best_found && !status.best_zero;
      end
      bnms_pkg::ST_TEST: cmd.push_survivor = !status.a_supp;
      bnms_pkg::ST_SUPP_INIT: cmd.scan_clr = 1'b1;
      bnms_pkg::ST_SUPP: begin
        cmd.rd_en = 1'b1;
        cmd.supp_mode = 1'b1;
      end
      bnms_pkg::ST_SUPP_DRAIN: cmd.supp_mode = 1'b1;
      bnms_pkg::ST_FLUSH: cmd.flush = 1'b1;
      default: cmd = '0;
    endcase
  end

  a_find_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == bnms_pkg::ST_FIND_INIT) |-> status.pipe_idle)
    else $error("rank search started with suppression still in flight");
  a_supp_only_survivor: assert property (@(posedge clk) disable iff (rst)
    (state == bnms_pkg::ST_SUPP_INIT) |-> $past(state == bnms_pkg::ST_TEST && !status.a_supp))
    else $error("suppression scan without a surviving box");
  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == bnms_pkg::ST_FLUSH) |=> (state == bnms_pkg::ST_IDLE))
    else $error("flush did not return to idle");

endmodule

// File: rtl/bnms_dp.sv
module bnms_dp #(
  parameter int MAX_BOXES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bnms_pkg::cmd_t      cmd,
  input  bnms_pkg::box_req_t  box_in,
  input  logic [15:0]         iou_threshold,
  output bnms_pkg::status_t   status,
  output bnms_pkg::box_res_t  result,
  output logic                result_valid
);

  localparam int IDXW = $clog2(MAX_BOXES);
  localparam int CNTW = IDXW + 1;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_BOXES);

  bnms_pkg::entry_t mem [MAX_BOXES];
  bnms_pkg::entry_t rd_data, best, a_box, pend;
  logic [IDXW-1:0]  addr, rd_idx, best_idx, a_idx, prev_idx;
  logic [CNTW-1:0]  cnt;
  logic [MAX_BOXES-1:0] marks;
  logic             ovf, rd_vld, best_found, prev_vld, pend_vld;
  logic [15:0]      prev_conf;

  // IoU pipeline
  logic             v1, v2, v3, v4;
  logic [IDXW-1:0]  idx1, idx2, idx3, idx4;
  logic [15:0]      ix1, iy1, wa1, ha1, wb1, hb1;
  logic [31:0]      inter2, aa2, ab2;
  logic [31:0]      inter3, inter4;
  logic [33:0]      uni3;
  logic [49:0]      rhs4;
  logic             hit;
  logic             cand_after, better, b_after, b_qual;

  // store incoming boxes
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt < CNT_MAX)) begin
      mem[cnt[IDXW-1:0]] <= '{cls: box_in.box_class, conf: box_in.confidence,
                              lx: box_in.left_x, ty: box_in.top_y,
                              rx: box_in.right_x, by: box_in.bottom_y};
    end
    rd_data <= mem[addr];
    rd_idx  <= addr;
  end

  // scan address and read strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.scan_clr) addr <= '0;
      else if (cmd.rd_en) addr <= addr + 1'b1;
    end
  end

  assign status.scan_end = ({1'b0, addr} == (cnt - 1'b1));

  // rank search: best box strictly after the previous winner
  always_comb begin
    cand_after = !prev_vld || (rd_data.conf < prev_conf) ||
                 ((rd_data.conf == prev_conf) && (rd_idx > prev_idx));
    better = !best_found || (rd_data.conf > best.conf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      prev_vld   <= 1'b0;
    end else begin
      if (cmd.find_clr) begin
        best_found <= 1'b0;
      end else if (rd_vld && !cmd.supp_mode && cand_after && better) begin
        best_found <= 1'b1;
      end
      if (cmd.take_winner) prev_vld <= 1'b1;
      else if (cmd.flush) prev_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && !cmd.supp_mode && cand_after && better) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
    if (cmd.take_winner) begin
      a_box     <= best;
      a_idx     <= best_idx;
      prev_conf <= best.conf;
      prev_idx  <= best_idx;
    end
  end

  assign status.best_found = best_found;
  assign status.best_zero  = (best.conf == 16'd0);
  assign status.a_supp     = marks[a_idx];

  // candidates for suppression: same class, live, ranked below the winner
  always_comb begin
    b_after = (rd_data.conf < a_box.conf) ||
              ((rd_data.conf == a_box.conf) && (rd_idx > a_idx));
    b_qual  = (rd_data.cls == a_box.cls) && (rd_data.conf != 16'd0) && b_after &&
              !marks[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= rd_vld && cmd.supp_mode && b_qual;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // overlap extents, products, union, threshold product
  always_ff @(posedge clk) begin
    idx1 <= rd_idx;
    ix1  <= bnms_pkg::span((a_box.lx > rd_data.lx) ? a_box.lx : rd_data.lx,
                           (a_box.rx < rd_data.rx) ? a_box.rx : rd_data.rx);
    iy1  <= bnms_pkg::span((a_box.ty > rd_data.ty) ? a_box.ty : rd_data.ty,
                           (a_box.by < rd_data.by) ? a_box.by : rd_data.by);
    wa1  <= bnms_pkg::span(a_box.lx, a_box.rx);
    ha1  <= bnms_pkg::span(a_box.ty, a_box.by);
    wb1  <= bnms_pkg::span(rd_data.lx, rd_data.rx);
    hb1  <= bnms_pkg::span(rd_data.ty, rd_data.by);

    idx2   <= idx1;
    inter2 <= ix1 * iy1;
    aa2    <= wa1 * ha1;
    ab2    <= wb1 * hb1;

    idx3   <= idx2;
    inter3 <= inter2;
    uni3   <= {2'b00, aa2} + {2'b00, ab2} - {2'b00, inter2} + bnms_pkg::IOU_EPS;

    idx4   <= idx3;
    inter4 <= inter3;
    rhs4   <= iou_threshold * uni3;
  end

  assign hit = v4 && ({2'b00, inter4, 16'h0000} > rhs4);
  assign status.pipe_idle = !rd_vld && !v1 && !v2 && !v3 && !v4;

  // set bookkeeping: count, overflow, suppression marks
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      ovf   <= 1'b0;
      marks <= '0;
    end else if (cmd.flush) begin
      cnt   <= '0;
      ovf   <= 1'b0;
      marks <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt < CNT_MAX) cnt <= cnt + 1'b1;
        else ovf <= 1'b1;
      end
      if (hit) marks[idx4] <= 1'b1;
    end
  end

  // hold one survivor back so the last one can carry the final mark
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.push_survivor && pend_vld) || cmd.flush;
      if (cmd.push_survivor) pend_vld <= 1'b1;
      else if (cmd.flush) pend_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_survivor) pend <= a_box;
    if (cmd.flush && !pend_vld) begin
      result <= '{kept_class: 8'd0, kept_confidence: 16'd0, kept_left_x: 16'd0,
                  kept_top_y: 16'd0, kept_right_x: 16'd0, kept_bottom_y: 16'd0,
                  final_result: 1'b1, nothing_kept: 1'b1, set_overflowed: ovf};
    end else if (cmd.push_survivor || cmd.flush) begin
      result.kept_class      <= pend.cls;
      result.kept_confidence <= pend.conf;
      result.kept_left_x     <= pend.lx;
      result.kept_top_y      <= pend.ty;
      result.kept_right_x    <= pend.rx;
      result.kept_bottom_y   <= pend.by;
      result.final_result    <= cmd.flush;
      result.nothing_kept    <= 1'b0;
      result.set_overflowed  <= ovf;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_MAX)
    else $error("box count beyond capacity");
  a_no_self_supp: assert property (@(posedge clk) disable iff (rst)
    hit |-> (idx4 != a_idx))
    else $error("winner marked as suppressed by itself");
  a_winner_found: assert property (@(posedge clk) disable iff (rst)
    cmd.take_winner |-> best_found)
    else $error("winner taken without a search hit");

endmodule

// File: rtl/box_nms_per_class.sv
// Boxes load at one per cycle while idle; busy stays low while a set is being loaded.
// After the last box, ranking and suppression run on one memory read port:
// each rank step scans all N stored boxes, and each surviving box then adds a
// suppression scan of the N boxes through the IoU pipe before the next rank step.
// Each result is a one-cycle strobe; the last one appears in the cycle busy falls.
// Synchronous reset clears counts and marks and sets the threshold to its reset value; box storage is not reset.
module box_nms_per_class #(
  parameter int MAX_BOXES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bnms_pkg::box_req_t  box_in,
  output bnms_pkg::box_res_t  result,
  output logic                result_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  bnms_pkg::cmd_t    cmd;
  bnms_pkg::status_t status;
  logic [15:0]       iou_threshold;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= bnms_pkg::IOU_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iou_threshold <= cfg_data;
    end
  end

  bnms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .last_box (box_in.last_box),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  bnms_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .box_in        (box_in),
    .iou_threshold (iou_threshold),
    .status        (status),
    .result        (result),
    .result_valid  (result_valid)
  );

endmodule
